>>> rtl/stn_pkg.sv
// ----------------------------------------------------------------------------
// stn_pkg: shared constants and character helpers for the text normalizer
// Character codes, class tests and case conversion used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package stn_pkg;

    localparam int unsigned CHAR_W = 8;

    // Result queue depth; must be a power of two and at least 2
    localparam int unsigned RESULT_DEPTH = 4;

    typedef logic [CHAR_W-1:0] char_t;

    typedef struct packed {
        logic  last;
        char_t ch;
    } result_t;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_PERIOD = 8'h2E;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_QUEST  = 8'h3F;
    localparam char_t CH_COLON  = 8'h3A;
    localparam char_t CH_SEMI   = 8'h3B;
    localparam char_t CH_EXCL   = 8'h21;
    localparam char_t CH_UP_A   = 8'h41;
    localparam char_t CH_UP_Z   = 8'h5A;
    localparam char_t CH_LO_A   = 8'h61;
    localparam char_t CH_LO_Z   = 8'h7A;
    localparam char_t CASE_DIFF = 8'h20;

    function automatic logic is_ws(input char_t c);
        logic r;
        case (c) inside
            CH_SPACE, CH_TAB, CH_LF: r = 1'b1;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_punct(input char_t c);
        logic r;
        case (c) inside
            CH_COMMA, CH_PERIOD, CH_LPAREN, CH_RPAREN,
            CH_QUEST, CH_COLON, CH_SEMI, CH_EXCL: r = 1'b1;
            default:                              r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_sentence_end(input char_t c);
        logic r;
        case (c) inside
            CH_PERIOD, CH_QUEST, CH_EXCL: r = 1'b1;
            default:                      r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic char_t to_upper(input char_t c);
        char_t r;
        case (c) inside
            [CH_LO_A:CH_LO_Z]: r = c - CASE_DIFF;
            default:           r = c;
        endcase
        return r;
    endfunction

    function automatic char_t to_lower(input char_t c);
        char_t r;
        case (c) inside
            [CH_UP_A:CH_UP_Z]: r = c + CASE_DIFF;
            default:           r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sentence_text_normalizer_core.sv
// ----------------------------------------------------------------------------
// sentence_text_normalizer_core: streaming sentence text normalizer
// Trims and collapses whitespace, drops whitespace before punctuation and
// the string end, fixes letter case per sentence, closes each string with
// a terminator marked last.
// ----------------------------------------------------------------------------
// Path: the input register captures each item, then one processing step writes its
//   results into the result queue, which drives the output.
// Throughput: one item per cycle while the queue has room; the output drains one
//   result per cycle, so an item with two results needs two output transfers.
//   The input stalls while the 4-entry result queue holds more than two results.
// Reset: rst_n clears the string state, the input valid flag and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sentence_text_normalizer_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [stn_pkg::CHAR_W-1:0] in_char,
    input  wire logic                       end_of_text,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [stn_pkg::CHAR_W-1:0] out_char,
    output logic                            last
);

    localparam int unsigned DEPTH = stn_pkg::RESULT_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // Input register
    logic           in_valid_reg;
    stn_pkg::char_t in_char_reg;
    logic           in_eot_reg;

    // String state
    logic           started_reg,  started_next;
    stn_pkg::char_t pending_reg,  pending_next;
    stn_pkg::char_t prev_reg,     prev_next;

    // Result queue
    stn_pkg::result_t   fifo_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg,  count_next;

    logic             advance;
    logic             pop;
    logic [1:0]       push_n;
    stn_pkg::result_t res0, res1;
    logic             emit_sp;
    logic             upper;
    stn_pkg::char_t   cased;

    // Advance only when the queue can take two results
    assign advance  = in_valid_reg && (count_reg <= CNT_W'(DEPTH - 2));
    assign in_ready = !in_valid_reg || advance;
    assign pop      = out_valid && out_ready;

    always_comb
    begin
        started_next = started_reg;
        pending_next = pending_reg;
        prev_next    = prev_reg;
        push_n       = 2'd0;
        res0         = '{last: 1'b0, ch: stn_pkg::CH_NUL};
        res1         = '{last: 1'b0, ch: stn_pkg::CH_NUL};
        emit_sp      = (pending_reg != stn_pkg::CH_NUL) && !stn_pkg::is_punct(in_char_reg);
        // Held whitespace is never a sentence end, so only prev matters
        upper        = !started_reg || (!emit_sp && stn_pkg::is_sentence_end(prev_reg));
        cased        = upper ? stn_pkg::to_upper(in_char_reg)
                             : stn_pkg::to_lower(in_char_reg);
        if (advance)
        begin
            if (in_eot_reg)
            begin
                res0         = '{last: 1'b1, ch: stn_pkg::CH_NUL};
                push_n       = 2'd1;
                started_next = 1'b0;
                pending_next = stn_pkg::CH_NUL;
                prev_next    = stn_pkg::CH_NUL;
            end
            else if (in_char_reg == stn_pkg::CH_NUL)
            begin
                push_n = 2'd0;
            end
            else if (stn_pkg::is_ws(in_char_reg))
            begin
                // Hold only the first whitespace of a run, tab as space
                if (started_reg && (pending_reg == stn_pkg::CH_NUL))
                begin
                    pending_next = (in_char_reg == stn_pkg::CH_TAB) ? stn_pkg::CH_SPACE
                                                                    : in_char_reg;
                end
            end
            else
            begin
                if (emit_sp)
                begin
                    res0   = '{last: 1'b0, ch: pending_reg};
                    res1   = '{last: 1'b0, ch: cased};
                    push_n = 2'd2;
                end
                else
                begin
                    res0   = '{last: 1'b0, ch: cased};
                    push_n = 2'd1;
                end
                pending_next = stn_pkg::CH_NUL;
                started_next = 1'b1;
                prev_next    = cased;
            end
        end
    end

    assign count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            started_reg  <= 1'b0;
            pending_reg  <= stn_pkg::CH_NUL;
            prev_reg     <= stn_pkg::CH_NUL;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            started_reg <= started_next;
            pending_reg <= pending_next;
            prev_reg    <= prev_next;
            wr_ptr_reg  <= wr_ptr_reg + PTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_char_reg <= in_char;
            in_eot_reg  <= end_of_text;
        end
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_char  = fifo_mem[rd_ptr_reg].ch;
    assign last      = fifo_mem[rd_ptr_reg].last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count exceeds depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (count_reg <= CNT_W'(DEPTH) - CNT_W'(push_n)))
        else $error("result queue overflow on push");

    a_pending_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != stn_pkg::CH_NUL) |-> started_reg)
        else $error("whitespace held before text started");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eot_reg) |=> (!started_reg && (pending_reg == stn_pkg::CH_NUL)))
        else $error("string state not cleared after terminator");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CNT_W'(DEPTH)) |->
            (CNT_W'(PTR_W'(wr_ptr_reg - rd_ptr_reg)) == count_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> tb/sentence_text_normalizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sentence_text_normalizer_checker: result scoreboard for the text normalizer
// Watches both channels and predicts the normalized stream from each input
// transfer. Every output transfer is compared in order with the prediction,
// and the failures are counted for the testbench top.
// ----------------------------------------------------------------------------

module sentence_text_normalizer_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  stn_pkg::char_t in_char,
    input  logic           end_of_text,
    input  logic           out_valid,
    input  logic           out_ready,
    input  stn_pkg::char_t out_char,
    input  logic           last,
    output int             fail_count,
    output int             expected_left,
    output int             results_seen
);

    // Normalizer state as the text is seen from outside
    logic             started;
    stn_pkg::char_t   held_ws;
    stn_pkg::char_t   prev_out;
    stn_pkg::result_t expected_chars[$];

    task automatic normalize_char(input stn_pkg::char_t c, input logic eot);
        stn_pkg::char_t cased;
        logic           after_stop;
        begin
            if (eot) begin
                expected_chars.push_back(
                    stn_pkg::result_t'{last: 1'b1, ch: stn_pkg::CH_NUL});
                started  = 1'b0;
                held_ws  = stn_pkg::CH_NUL;
                prev_out = stn_pkg::CH_NUL;
            end else if (c == stn_pkg::CH_NUL) begin
                // drop zero bytes without touching the state
            end else if (c == stn_pkg::CH_SPACE || c == stn_pkg::CH_TAB ||
                         c == stn_pkg::CH_LF) begin
                // hold only the first whitespace of a run, tab becomes space
                if (started && held_ws == stn_pkg::CH_NUL)
                    held_ws = (c == stn_pkg::CH_TAB) ? stn_pkg::CH_SPACE : c;
            end else begin
                if (held_ws != stn_pkg::CH_NUL) begin
                    case (c)
                        stn_pkg::CH_COMMA, stn_pkg::CH_PERIOD,
                        stn_pkg::CH_LPAREN, stn_pkg::CH_RPAREN,
                        stn_pkg::CH_QUEST, stn_pkg::CH_COLON,
                        stn_pkg::CH_SEMI, stn_pkg::CH_EXCL: ;
                        default:
                        begin
                            expected_chars.push_back(
                                stn_pkg::result_t'{last: 1'b0, ch: held_ws});
                            prev_out = held_ws;
                        end
                    endcase
                    held_ws = stn_pkg::CH_NUL;
                end
                after_stop = (prev_out == stn_pkg::CH_PERIOD) ||
                             (prev_out == stn_pkg::CH_EXCL) ||
                             (prev_out == stn_pkg::CH_QUEST);
                cased = c;
                if (!started || after_stop) begin
                    if (c >= stn_pkg::CH_LO_A && c <= stn_pkg::CH_LO_Z)
                        cased = c - stn_pkg::CASE_DIFF;
                end else if (c >= stn_pkg::CH_UP_A && c <= stn_pkg::CH_UP_Z) begin
                    cased = c + stn_pkg::CASE_DIFF;
                end
                expected_chars.push_back(stn_pkg::result_t'{last: 1'b0, ch: cased});
                started  = 1'b1;
                prev_out = cased;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            started  = 1'b0;
            held_ws  = stn_pkg::CH_NUL;
            prev_out = stn_pkg::CH_NUL;
            expected_chars.delete();
            fail_count    = 0;
            results_seen  = 0;
            expected_left = 0;
        end else begin
            if (in_valid && in_ready)
                normalize_char(in_char, end_of_text);
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_chars.size() == 0) begin
                    if (fail_count < 10)
                        $display("mismatch: unexpected result char %h last %b",
                                 out_char, last);
                    fail_count++;
                end else begin
                    stn_pkg::result_t want;
                    want = expected_chars.pop_front();
                    if (want.ch !== out_char || want.last !== last) begin
                        if (fail_count < 10)
                            $display("mismatch: expected char %h last %b, got char %h last %b",
                                     want.ch, want.last, out_char, last);
                        fail_count++;
                    end
                end
            end
            expected_left = expected_chars.size();
        end
    end

endmodule

>>> tb/tb_sentence_text_normalizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sentence_text_normalizer_core: testbench for the text normalizer core
// Sends directed strings and then random sentence-like text with bursts of
// idling on both sides, a long output stall and a drain pause. A checker
// module predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_sentence_text_normalizer_core;

    localparam int TOTAL_ITEMS = 1800;
    localparam int LONG_HOLD   = 400;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    stn_pkg::char_t in_char;
    logic           end_of_text;
    logic           out_valid;
    logic           out_ready;
    stn_pkg::char_t out_char;
    logic           last;

    int fail_count;
    int expected_left;
    int results_seen;

    int items_sent;
    int strings_sent;
    int hold_requests;
    int holds_done;
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;

    sentence_text_normalizer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last        (last)
    );

    sentence_text_normalizer_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .last          (last),
        .fail_count    (fail_count),
        .expected_left (expected_left),
        .results_seen  (results_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input stn_pkg::char_t c, input logic eot);
        begin
            if (src_idle_on && $urandom_range(0, 7) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            in_valid    <= 1'b1;
            in_char     <= c;
            end_of_text <= eot;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            items_sent++;
            if (eot)
                strings_sent++;
            @(negedge clk);
        end
    endtask

    task automatic send_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                send_item(stn_pkg::char_t'(s[i]), 1'b0);
        end
    endtask

    function automatic stn_pkg::char_t pick_char(input bit ws_only);
        int unsigned    roll;
        stn_pkg::char_t c;
        begin
            roll = ws_only ? 50 : $urandom_range(0, 99);
            if (roll < 45) begin
                if ($urandom_range(0, 1))
                    c = stn_pkg::char_t'(stn_pkg::CH_UP_A + $urandom_range(0, 25));
                else
                    c = stn_pkg::char_t'(stn_pkg::CH_LO_A + $urandom_range(0, 25));
            end else if (roll < 70) begin
                case ($urandom_range(0, 2))
                    0:       c = stn_pkg::CH_SPACE;
                    1:       c = stn_pkg::CH_TAB;
                    default: c = stn_pkg::CH_LF;
                endcase
            end else if (roll < 85) begin
                case ($urandom_range(0, 7))
                    0:       c = stn_pkg::CH_COMMA;
                    1:       c = stn_pkg::CH_PERIOD;
                    2:       c = stn_pkg::CH_LPAREN;
                    3:       c = stn_pkg::CH_RPAREN;
                    4:       c = stn_pkg::CH_QUEST;
                    5:       c = stn_pkg::CH_COLON;
                    6:       c = stn_pkg::CH_SEMI;
                    default: c = stn_pkg::CH_EXCL;
                endcase
            end else begin
                c = stn_pkg::char_t'($urandom_range(0, 255));
            end
            return c;
        end
    endfunction

    task automatic send_random_text();
        int len;
        bit ws_only;
        begin
            len     = $urandom_range(1, 30);
            ws_only = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < len; i++)
                send_item(pick_char(ws_only), 1'b0);
            send_item(stn_pkg::char_t'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            wait (expected_left == 0);
            repeat ($urandom_range(3, 10)) @(negedge clk);
        end
    endtask

    // Output side: random stalls, plus one long hold counted here
    initial
    begin
        int hold_cycles;
        out_ready  = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                out_ready   <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < LONG_HOLD) begin
                    @(negedge clk);
                    hold_cycles++;
                end
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_char       = stn_pkg::CH_NUL;
        end_of_text   = 1'b0;
        items_sent    = 0;
        strings_sent  = 0;
        hold_requests = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Leading whitespace, zero byte, held runs before a mark and a letter,
        // bytes above 127, sentence ends
        send_text(" \t\nhI");
        send_item(stn_pkg::CH_NUL, 1'b0);
        send_text(" \t,wORLD!  x");
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_text("?\n");
        send_item(8'hFF, 1'b1);
        // all-whitespace string, then an empty one
        send_text(" \t");
        send_item(stn_pkg::CH_NUL, 1'b1);
        send_item(8'h5A, 1'b1);

        while (items_sent < 700)
            send_random_text();

        // Stall the output long enough that the core backs up its input
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_item(stn_pkg::char_t'(stn_pkg::CH_LO_A + $urandom_range(0, 25)), 1'b0);
        send_item(stn_pkg::CH_NUL, 1'b1);

        wait_drained();

        while (items_sent < 1400)
            send_random_text();

        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (items_sent < TOTAL_ITEMS)
            send_random_text();

        in_valid <= 1'b0;
        wait (expected_left == 0);
        repeat (20) @(posedge clk);

        $display("tb: sent %0d input items in %0d strings, %0d results compared",
                 items_sent, strings_sent, results_seen);
        $display("tb: covered idle bursts, a %0d-cycle output hold and a drain pause",
                 LONG_HOLD);
        if (fail_count == 0 && expected_left == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
